FILE: hdl/assert_macros.svh
// assertion macros used by the queue top rtl file
// no dependencies; compiled out when NO_ASSERTIONS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CDLQ_ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

`define CDLQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`define CDLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`else

`define CDLQ_ASSERT_HOLDS(label, clk, rst, cond)
`define CDLQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CDLQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/cdlq_pkg.sv
// constants and command codes for the circular doubly linked queue
// no dependencies
package cdlq_pkg;

  localparam int POOL_SIZE = 16;
  localparam int IdW       = $clog2(POOL_SIZE);
  localparam int CmdW      = 2;
  localparam int ElemW     = 4;
  localparam int SizeW     = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SIZE   = 2'd2
  } cmd_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

FILE: hdl/cdlq_ifs.sv
// request and response channel interfaces of the queue
// depends on cdlq_pkg
interface cdlq_req_if import cdlq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [ElemW-1:0] elem;

  modport source (output valid, cmd, elem, input ready);
  modport sink   (input valid, cmd, elem, output ready);
endinterface

interface cdlq_rsp_if import cdlq_pkg::*;;
  logic             valid;
  logic             ready;
  logic             status;
  logic [SizeW-1:0] size;

  modport source (output valid, status, size, input ready);
  modport sink   (input valid, status, size, output ready);
endinterface

FILE: hdl/circular_doubly_linked_queue_top.sv
// channel | dir | payload              | notes
// req     | in  | cmd[1:0], elem[3:0]  | one beat per operation
// rsp     | out | status, size[4:0]    | one beat per request beat, in order
//
// one request beat per cycle while rsp is not stalled; a beat executes in the input register
// when the result register can advance, and its result is registered in the result register
// the link, flag and count registers are read and written in the execute cycle of each beat
// synchronous active-high reset clears flags, head, count and both valid bits
// a stalled response holds both stages; ready on req then follows ready on rsp if s1 is full
// depends on cdlq_pkg, cdlq_ifs and assert_macros.svh
`include "assert_macros.svh"

module circular_doubly_linked_queue_top import cdlq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cdlq_req_if.sink   req,
  cdlq_rsp_if.source rsp
);

  logic             s1_valid;
  cmd_t             s1_cmd;
  logic [ElemW-1:0] s1_elem;

  logic             out_valid;
  logic             out_status;
  logic [SizeW-1:0] out_size;

  logic [IdW-1:0]   next_link [POOL_SIZE];
  logic [IdW-1:0]   prev_link [POOL_SIZE];
  logic [POOL_SIZE-1:0] in_queue;
  logic [IdW-1:0]   head_id;
  logic [SizeW-1:0] elem_count;
  logic [SizeW-1:0] elem_count_next;

  logic           advance;
  logic           exe;
  logic [IdW-1:0] e;
  logic           e_ok;
  logic           member;
  logic [IdW-1:0] tail;
  logic [IdW-1:0] p;
  logic [IdW-1:0] n;
  logic           app_ok;
  logic           rem_ok;
  logic           status_next;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;
  assign exe       = s1_valid && advance;

  assign e      = s1_elem[IdW-1:0];
  assign e_ok   = 32'(s1_elem) < 32'(POOL_SIZE);
  assign member = in_queue[e];
  assign tail   = prev_link[head_id];
  assign p      = prev_link[e];
  assign n      = next_link[e];

  always_comb begin
    app_ok          = 1'b0;
    rem_ok          = 1'b0;
    status_next     = STATUS_ERR;
    elem_count_next = elem_count;
    case (s1_cmd)
      CMD_APPEND: begin
        app_ok = e_ok && !member;
      end
      CMD_REMOVE: begin
        rem_ok = e_ok && member && (elem_count != '0);
      end
      CMD_SIZE: begin
        status_next = STATUS_OK;
      end
      default: begin
        status_next = STATUS_ERR;
      end
    endcase
    if (app_ok) begin
      status_next     = STATUS_OK;
      elem_count_next = elem_count + SizeW'(1);
    end
    if (rem_ok) begin
      status_next     = STATUS_OK;
      elem_count_next = elem_count - SizeW'(1);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_cmd  <= cmd_t'(req.cmd);
      s1_elem <= req.elem;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exe) begin
      out_status <= status_next;
      out_size   <= elem_count_next;
    end
  end

  // flags, head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_queue   <= '0;
      head_id    <= '0;
      elem_count <= '0;
    end else if (exe) begin
      elem_count <= elem_count_next;
      if (app_ok) begin
        in_queue[e] <= 1'b1;
        if (elem_count == '0) begin
          head_id <= e;
        end
      end
      if (rem_ok) begin
        in_queue[e] <= 1'b0;
        if (elem_count != SizeW'(1) && e == head_id) begin
          head_id <= n;
        end
      end
    end
  end

  // link tables, undefined until written
  always_ff @(posedge clk) begin
    if (exe && app_ok) begin
      if (elem_count == '0) begin
        next_link[e] <= e;
        prev_link[e] <= e;
      end else begin
        prev_link[e]       <= tail;
        next_link[e]       <= head_id;
        next_link[tail]    <= e;
        prev_link[head_id] <= e;
      end
    end
    if (exe && rem_ok && elem_count != SizeW'(1)) begin
      next_link[p] <= n;
      prev_link[n] <= p;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.size   = out_size;

  `CDLQ_ASSERT_HOLDS(a_count_matches_flags, clk, rst, 32'($countones(in_queue)) == 32'(elem_count))
  `CDLQ_ASSERT_HOLDS(a_count_in_range, clk, rst, 32'(elem_count) <= 32'(POOL_SIZE))
  `CDLQ_ASSERT_IMPLIES(a_head_is_member, clk, rst, elem_count != '0, in_queue[head_id])
  `CDLQ_ASSERT_IMPLIES(a_tail_links_head, clk, rst, elem_count != '0, next_link[tail] == head_id)
  `CDLQ_ASSERT_NEXT(a_append_grows, clk, rst, exe && app_ok, elem_count == $past(elem_count) + SizeW'(1))

endmodule

FILE: dv/circular_doubly_linked_queue_top_test.sv
// testbench for the circular doubly linked queue: directed and random operations
// checked beat by beat against a behavioural copy of the link tables
// depends on cdlq_pkg, cdlq_ifs and circular_doubly_linked_queue_top
module circular_doubly_linked_queue_top_test import cdlq_pkg::*;;

  localparam logic [CmdW-1:0] CMD_UNUSED = CmdW'(3);
  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [ElemW-1:0] elem;
    bit               drain;
  } queue_op_t;

  typedef struct {
    logic             status;
    logic [SizeW-1:0] size;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             req_valid = 1'b0;
  logic [CmdW-1:0]  req_cmd   = '0;
  logic [ElemW-1:0] req_elem  = '0;
  logic             rsp_ready = 1'b0;

  cdlq_req_if req_bus ();
  cdlq_rsp_if rsp_bus ();

  assign req_bus.valid = req_valid;
  assign req_bus.cmd   = req_cmd;
  assign req_bus.elem  = req_elem;
  assign rsp_bus.ready = rsp_ready;

  circular_doubly_linked_queue_top u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #5 clk = ~clk;

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];
  int unsigned   ops_accepted    = 0;
  int unsigned   results_checked = 0;
  int unsigned   mismatches      = 0;
  int unsigned   quiet_cycles    = 0;
  int            send_idle_pct   = 0;
  int            rsp_stall_pct   = 0;

  // behavioural copy of the queue
  logic [IdW-1:0]      succ_of[POOL_SIZE];
  logic [IdW-1:0]      pred_of[POOL_SIZE];
  bit [POOL_SIZE-1:0]  is_member    = '0;
  logic [IdW-1:0]      head_elem    = '0;
  int                  member_count = 0;

  // stimulus-side view of membership, used only to shape the random ops
  bit [POOL_SIZE-1:0]  planned_members = '0;
  bit                  filling         = 1'b1;

  function automatic queue_result_t predict_link_op(input logic [CmdW-1:0] cmd,
                                                    input logic [ElemW-1:0] e);
    queue_result_t  r;
    logic [IdW-1:0] id;
    logic [IdW-1:0] tail;
    logic [IdW-1:0] p;
    logic [IdW-1:0] n;
    r.status = STATUS_OK;
    id = IdW'(e);
    case (cmd)
      CMD_APPEND: begin
        if (int'(e) >= POOL_SIZE || is_member[id]) begin
          r.status = STATUS_ERR;
        end else begin
          if (member_count == 0) begin
            head_elem   = id;
            succ_of[id] = id;
            pred_of[id] = id;
          end else begin
            tail               = pred_of[head_elem];
            pred_of[id]        = tail;
            succ_of[id]        = head_elem;
            succ_of[tail]      = id;
            pred_of[head_elem] = id;
          end
          is_member[id] = 1'b1;
          member_count++;
        end
      end
      CMD_REMOVE: begin
        if (int'(e) >= POOL_SIZE || member_count == 0 || !is_member[id]) begin
          r.status = STATUS_ERR;
        end else begin
          if (member_count != 1) begin
            p          = pred_of[id];
            n          = succ_of[id];
            succ_of[p] = n;
            pred_of[n] = p;
            if (id == head_elem) head_elem = n;
          end
          is_member[id] = 1'b0;
          member_count--;
        end
      end
      CMD_SIZE: r.status = STATUS_OK;
      default:  r.status = STATUS_ERR;
    endcase
    r.size = SizeW'(member_count);
    return r;
  endfunction

  task automatic push_op(input logic [CmdW-1:0] cmd, input logic [ElemW-1:0] e,
                         input bit drain);
    queue_op_t op;
    op.cmd   = cmd;
    op.elem  = e;
    op.drain = drain;
    if (cmd == CMD_APPEND) planned_members[e] = 1'b1;
    else if (cmd == CMD_REMOVE) planned_members[e] = 1'b0;
    pending_ops.push_back(op);
  endtask

  task automatic plan_random_ops(input int count);
    int               r;
    int               n_members;
    bit               want_append;
    logic [ElemW-1:0] e;
    logic [CmdW-1:0]  c;
    for (int i = 0; i < count; i++) begin
      n_members = $countones(planned_members);
      if (n_members == POOL_SIZE) filling = 1'b0;
      else if (n_members == 0) filling = 1'b1;
      r = $urandom_range(99);
      e = ElemW'($urandom_range(POOL_SIZE - 1));
      if (r < 6) begin
        if ($urandom_range(1) != 0) c = CMD_SIZE;
        else c = CMD_UNUSED;
      end else if (r < 14) begin
        // unguided element: often a duplicate or an absent id
        if ($urandom_range(1) != 0) c = CMD_APPEND;
        else c = CMD_REMOVE;
      end else begin
        want_append = filling ? ($urandom_range(99) < 70) : ($urandom_range(99) < 30);
        if (n_members == POOL_SIZE) want_append = 1'b0;
        else if (n_members == 0) want_append = 1'b1;
        if (want_append) c = CMD_APPEND;
        else c = CMD_REMOVE;
        while (planned_members[e] == want_append) e = ElemW'($urandom_range(POOL_SIZE - 1));
      end
      push_op(c, e, (i == 0) || ($urandom_range(99) == 0));
    end
  endtask

  task automatic wait_ops_sent;
    while (pending_ops.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_ops
    bit          took;
    int unsigned in_flight;
    queue_op_t   op;
    took = req_valid && req_bus.ready;
    if (took) ops_accepted <= ops_accepted + 1;
    in_flight = ops_accepted + (took ? 1 : 0) - results_checked;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || took) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_ops[0].drain && in_flight != 0)) begin
        op = pending_ops.pop_front();
        req_valid <= 1'b1;
        req_cmd   <= op.cmd;
        req_elem  <= op.elem;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (req_valid && req_bus.ready) begin
      expected_results.push_back(predict_link_op(req_cmd, req_elem));
    end
    if (!rst && rsp_bus.valid && rsp_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: status %0d size %0d", rsp_bus.status, rsp_bus.size);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp_bus.status);
          mismatches++;
        end
        if (rsp_bus.size !== want.size) begin
          $error("size mismatch: expected %0d, actual %0d", want.size, rsp_bus.size);
          mismatches++;
        end
        results_checked <= results_checked + 1;
      end
    end
    rsp_ready <= !rst && ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if ((req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("circular_doubly_linked_queue_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_phases
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 70, 0, 34};
    stall_plan = '{0, 0, 70, 34};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_op(CMD_SIZE,   4'd0,  1'b0);
    push_op(CMD_REMOVE, 4'd0,  1'b0);
    push_op(CMD_UNUSED, 4'd15, 1'b0);
    push_op(CMD_APPEND, 4'd0,  1'b0);
    push_op(CMD_APPEND, 4'd15, 1'b0);
    push_op(CMD_APPEND, 4'd0,  1'b0);
    push_op(CMD_APPEND, 4'd7,  1'b0);
    push_op(CMD_REMOVE, 4'd15, 1'b0);
    push_op(CMD_REMOVE, 4'd0,  1'b0);
    push_op(CMD_REMOVE, 4'd9,  1'b0);
    push_op(CMD_REMOVE, 4'd7,  1'b0);
    push_op(CMD_REMOVE, 4'd7,  1'b0);
    push_op(CMD_APPEND, 4'd10, 1'b0);
    push_op(CMD_UNUSED, 4'd5,  1'b0);
    push_op(CMD_SIZE,   4'd15, 1'b0);
    wait_ops_sent();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      rsp_stall_pct = stall_plan[ph];
      plan_random_ops(360);
      wait_ops_sent();
    end

    while (pending_ops.size() != 0 || req_valid || results_checked != ops_accepted)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("circular_doubly_linked_queue_top verification clean");
    end else begin
      $display("circular_doubly_linked_queue_top verification failed");
    end
    $finish;
  end

endmodule

FILE: circular_doubly_linked_queue_top.f
+incdir+hdl
hdl/cdlq_pkg.sv
hdl/cdlq_ifs.sv
hdl/circular_doubly_linked_queue_top.sv
dv/circular_doubly_linked_queue_top_test.sv
